// ----- hdl/adv_data_sensor_extract_top_macros.svh -----
// Assertion macros shared by the advertising-data extractor modules.
`ifndef ADV_DATA_SENSOR_EXTRACT_TOP_MACROS_SVH
`define ADV_DATA_SENSOR_EXTRACT_TOP_MACROS_SVH

// Same-cycle implication, checked on clk outside of reset.
`define ADSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adse check failed: same-cycle rule");

// Next-cycle implication, checked on clk outside of reset.
`define ADSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adse check failed: next-cycle rule");

`endif

// ----- hdl/adse_pkg.sv -----
// Types and constants shared by the advertising-data extractor.
package adse_pkg;

    localparam logic [7:0]  MinBlock          = 8'd5;
    localparam logic [7:0]  BlockType         = 8'hFF;
    localparam logic [15:0] ServiceId         = 16'h55AA;
    localparam logic [7:0]  ServiceHdr        = 8'd3;
    localparam logic [2:0]  FieldBytes        = 3'd7;
    localparam logic [47:0] KnownAddressReset = 48'h842E_1431_BB5C;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_NO_BLOCK  = 2'd2,
        STATUS_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_LEN     = 7'b0000001,
        PH_TYPE    = 7'b0000010,
        PH_SVC_LO  = 7'b0000100,
        PH_SVC_HI  = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_CAPTURE = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [47:0] device_address;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         service_length;
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
        logic [15:0]        cell_voltage;
        logic [7:0]         charge_level;
    } out_beat_t;

endpackage

// ----- hdl/adse_parser.sv -----
// Input register and per-byte block parser that forms one result per packet.
`include "adv_data_sensor_extract_top_macros.svh"

module adse_parser
    import adse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_beat_t  byte_data,
    input  logic      address_we,
    input  logic [47:0] address_data,
    input  logic      out_free,
    output logic      res_load,
    output out_beat_t res_data
);

    logic        in_valid_reg;
    in_beat_t    in_beat_reg;
    logic [47:0] known_addr_reg;
    logic        advance;

    phase_t      phase_reg,   phase_next;
    logic [7:0]  remain_reg,  remain_next;
    logic [7:0]  blen_reg,    blen_next;
    logic [7:0]  svc_lo_reg,  svc_lo_next;
    logic        addr_ok_reg, addr_ok_next;
    logic [2:0]  fidx_reg,    fidx_next;
    logic [55:0] cap_reg,     cap_next;
    logic        match_reg,   match_next;

    // A beat only waits when it closes a packet and the result slot is busy.
    assign advance    = in_valid_reg && (!in_beat_reg.last_byte || out_free);
    assign byte_stall = in_valid_reg && !advance;
    assign res_load   = advance && in_beat_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            known_addr_reg <= KnownAddressReset;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
            end
            if (address_we)
            begin
                known_addr_reg <= address_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_beat_reg <= byte_data;
        end
    end

    always_comb
    begin
        phase_t      ph;
        logic [7:0]  rem;
        logic [7:0]  blen;
        logic [7:0]  slo;
        logic        aok;
        logic [2:0]  fidx;
        logic [55:0] cap;
        logic        mf;
        logic [7:0]  b;

        ph   = phase_reg;
        rem  = remain_reg;
        blen = blen_reg;
        slo  = svc_lo_reg;
        aok  = addr_ok_reg;
        fidx = fidx_reg;
        cap  = cap_reg;
        mf   = match_reg;
        b    = in_beat_reg.data_byte;

        if (in_beat_reg.first_byte)
        begin
            ph   = PH_LEN;
            rem  = '0;
            blen = '0;
            slo  = '0;
            fidx = '0;
            cap  = '0;
            mf   = 1'b0;
            aok  = (in_beat_reg.device_address == known_addr_reg);
        end

        case (ph)
            PH_LEN:
            begin
                rem = b;
                if (b < MinBlock)
                begin
                    ph = (b == 8'd0) ? PH_LEN : PH_SKIP;
                end
                else
                begin
                    blen = b;
                    ph   = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                rem = rem - 8'd1;
                if (b == BlockType)
                begin
                    ph = PH_SVC_LO;
                end
                else
                begin
                    ph = (rem == 8'd0) ? PH_LEN : PH_SKIP;
                end
            end
            PH_SVC_LO:
            begin
                slo = b;
                rem = rem - 8'd1;
                ph  = PH_SVC_HI;
            end
            PH_SVC_HI:
            begin
                if ({b, slo} == ServiceId)
                begin
                    mf   = 1'b1;
                    fidx = '0;
                    cap  = '0;
                    ph   = PH_CAPTURE;
                end
                else
                begin
                    rem = rem - 8'd1;
                    ph  = (rem == 8'd0) ? PH_LEN : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                rem = rem - 8'd1;
                if (rem == 8'd0)
                begin
                    ph = PH_LEN;
                end
            end
            PH_CAPTURE:
            begin
                cap  = cap | ({48'd0, b} << {fidx, 3'b000});
                fidx = fidx + 3'd1;
                if (fidx == FieldBytes)
                begin
                    ph = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        res_data = '0;
        if (!aok)
        begin
            res_data.status = STATUS_MISMATCH;
        end
        else if (!mf)
        begin
            res_data.status = STATUS_NO_BLOCK;
        end
        else
        begin
            res_data.service_length = blen - ServiceHdr;
            if (fidx != FieldBytes)
            begin
                res_data.status = STATUS_TRUNCATED;
            end
            else
            begin
                res_data.status       = STATUS_FOUND;
                res_data.temperature  = $signed(cap[15:0]);
                res_data.humidity     = $signed(cap[31:16]);
                res_data.cell_voltage = cap[47:32];
                res_data.charge_level = cap[55:48];
            end
        end

        if (in_beat_reg.last_byte)
        begin
            ph   = PH_LEN;
            rem  = '0;
            blen = '0;
            slo  = '0;
            aok  = 1'b0;
            fidx = '0;
            cap  = '0;
            mf   = 1'b0;
        end

        phase_next   = ph;
        remain_next  = rem;
        blen_next    = blen;
        svc_lo_next  = slo;
        addr_ok_next = aok;
        fidx_next    = fidx;
        cap_next     = cap;
        match_next   = mf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEN;
            remain_reg  <= '0;
            blen_reg    <= '0;
            svc_lo_reg  <= '0;
            addr_ok_reg <= 1'b0;
            fidx_reg    <= '0;
            cap_reg     <= '0;
            match_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            blen_reg    <= blen_next;
            svc_lo_reg  <= svc_lo_next;
            addr_ok_reg <= addr_ok_next;
            fidx_reg    <= fidx_next;
            cap_reg     <= cap_next;
            match_reg   <= match_next;
        end
    end

    `ADSE_ASSERT_NEXT(a_clear_after_last, res_load,
        phase_reg == PH_LEN && !match_reg && fidx_reg == 3'd0 && !addr_ok_reg)
    `ADSE_ASSERT_NOW(a_capture_index, phase_reg == PH_CAPTURE, fidx_reg < FieldBytes)
    `ADSE_ASSERT_NOW(a_done_index, phase_reg == PH_DONE, fidx_reg == FieldBytes && match_reg)
    `ADSE_ASSERT_NOW(a_stall_cause, byte_stall, in_beat_reg.last_byte && !out_free)

endmodule

// ----- hdl/adse_out_stage.sv -----
// Result register that holds one finished packet result until it is taken.
`include "adv_data_sensor_extract_top_macros.svh"

module adse_out_stage
    import adse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_load,
    input  out_beat_t res_data,
    output logic      out_free,
    output logic      result_valid,
    input  logic      result_stall,
    output out_beat_t result_data
);

    logic      valid_reg;
    out_beat_t data_reg;

    assign out_free     = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res_data;
        end
    end

    `ADSE_ASSERT_NOW(a_no_overwrite, res_load, out_free)
    `ADSE_ASSERT_NEXT(a_load_shows, res_load, valid_reg && data_reg == $past(res_data))
    `ADSE_ASSERT_NEXT(a_drain_empties, valid_reg && !result_stall && !res_load, !valid_reg)

endmodule

// ----- hdl/adv_data_sensor_extract_top.sv -----
// Top level of the advertising-data sensor extractor.
//
//   channel   valid          stall          payload        beat
//   bytes     byte_valid     byte_stall     byte_data      one payload byte
//   results   result_valid   result_stall   result_data    one result per packet
//   config    address_we     -              address_data   known sender address
//
// Every payload byte is parsed while it sits in the input register.
// A packet result appears in the result register in the cycle after its last byte is parsed.
// Bytes are accepted back to back; only a last byte waits, while the result register
// is full and stalled. Reset clears the parser and loads the default known address.

module adv_data_sensor_extract_top
    import adse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  in_beat_t    byte_data,
    output logic        result_valid,
    input  logic        result_stall,
    output out_beat_t   result_data,
    input  logic        address_we,
    input  logic [47:0] address_data
);

    logic      out_free;
    logic      res_load;
    out_beat_t res_data;

    adse_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .address_we   (address_we),
        .address_data (address_data),
        .out_free     (out_free),
        .res_load     (res_load),
        .res_data     (res_data)
    );

    adse_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_load     (res_load),
        .res_data     (res_data),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the advertising-data sensor extractor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adse_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int LongHold    = 150;
    localparam int DrainCycles = 4;

    // Tracks the parser of the block byte by byte and keeps the packet results
    // that are still owed by the block.
    class sensor_result_book;
        logic [47:0] known_addr;
        phase_t      parse_state;
        logic [7:0]  remaining;
        logic [7:0]  blen;
        logic [7:0]  svc_lo;
        bit          addr_ok;
        bit          matched;
        int          nfields;
        logic [55:0] captured;
        out_beat_t   pending_results[$];
        int          mismatches;

        function new();
            known_addr = KnownAddressReset;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            parse_state = PH_LEN;
            remaining = '0;
            blen = '0;
            svc_lo = '0;
            addr_ok = 1'b0;
            matched = 1'b0;
            nfields = 0;
            captured = '0;
        endfunction

        // Uses up one block byte; a failed compare skips the rest of the block.
        function void block_byte(bit keep, phase_t nxt);
            remaining = remaining - 8'd1;
            if (keep)
                parse_state = nxt;
            else
                parse_state = (remaining == 8'd0) ? PH_LEN : PH_SKIP;
        endfunction

        function void note_byte(in_beat_t b);
            out_beat_t r;
            if (b.first_byte)
            begin
                clear();
                addr_ok = (b.device_address == known_addr);
            end
            case (parse_state)
                PH_LEN:
                begin
                    remaining = b.data_byte;
                    if (b.data_byte < MinBlock)
                        parse_state = (b.data_byte == 8'd0) ? PH_LEN : PH_SKIP;
                    else
                    begin
                        blen = b.data_byte;
                        parse_state = PH_TYPE;
                    end
                end
                PH_TYPE:
                    block_byte(b.data_byte == BlockType, PH_SVC_LO);
                PH_SVC_LO:
                begin
                    svc_lo = b.data_byte;
                    block_byte(1'b1, PH_SVC_HI);
                end
                PH_SVC_HI:
                begin
                    if ({b.data_byte, svc_lo} == ServiceId)
                    begin
                        matched = 1'b1;
                        nfields = 0;
                        captured = '0;
                        parse_state = PH_CAPTURE;
                    end
                    else
                        block_byte(1'b0, PH_LEN);
                end
                PH_SKIP:
                begin
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                        parse_state = PH_LEN;
                end
                PH_CAPTURE:
                begin
                    if (nfields < FieldBytes)
                    begin
                        captured[8*nfields +: 8] = b.data_byte;
                        nfields++;
                    end
                    if (nfields >= FieldBytes)
                        parse_state = PH_DONE;
                end
                default:
                    ;
            endcase
            if (b.last_byte)
            begin
                r = '0;
                if (!addr_ok)
                    r.status = STATUS_MISMATCH;
                else if (!matched)
                    r.status = STATUS_NO_BLOCK;
                else
                begin
                    r.service_length = blen - ServiceHdr;
                    if (nfields < FieldBytes)
                        r.status = STATUS_TRUNCATED;
                    else
                    begin
                        r.status = STATUS_FOUND;
                        r.temperature = captured[15:0];
                        r.humidity = captured[31:16];
                        r.cell_voltage = captured[47:32];
                        r.charge_level = captured[55:48];
                    end
                end
                pending_results.push_back(r);
                clear();
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.service_length !== want.service_length
                || got.temperature !== want.temperature || got.humidity !== want.humidity
                || got.cell_voltage !== want.cell_voltage
                || got.charge_level !== want.charge_level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    in_beat_t    byte_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    out_beat_t   result_data;
    logic        address_we = 1'b0;
    logic [47:0] address_data = '0;

    sensor_result_book sb;
    logic [7:0]  packet_bytes[$];
    bit          idling = 1'b1;
    bit          long_hold_done = 1'b0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int unsigned cycle_count = 0;

    adv_data_sensor_extract_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .address_we   (address_we),
        .address_data (address_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Outputs are stable by the falling edge, so a beat seen there is taken at
    // the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result_data);
            results_seen++;
        end
    end

    // Result side: random stall bursts, plus one long hold-off that lets the
    // block fill up while bytes keep coming.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && results_seen >= 12)
            begin
                long_hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (LongHold) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_packet(input logic [47:0] addr, input bit headless,
                               input int restart_at);
        in_beat_t beat;
        int       gap_odds;
        bit       taken;
        gap_odds = (idling && $urandom_range(0, 2) != 0) ? 4 : 0;
        foreach (packet_bytes[i])
        begin
            beat.data_byte = packet_bytes[i];
            beat.first_byte = (i == 0 && !headless) || i == restart_at;
            beat.last_byte = (i == packet_bytes.size() - 1);
            beat.device_address = beat.first_byte ? addr : {16'($urandom), 32'($urandom)};
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_data <= beat;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = !byte_stall;
                if (taken)
                begin
                    sb.note_byte(beat);
                    bytes_sent++;
                end
                @(posedge clk);
            end
        end
    endtask

    function automatic void push_random(int n);
        repeat (n) packet_bytes.push_back(8'($urandom));
    endfunction

    // A block the parser walks past: empty, short, or long with random contents.
    function automatic void push_filler();
        int n;
        case ($urandom_range(0, 2))
            0: packet_bytes.push_back(8'd0);
            1:
            begin
                n = $urandom_range(1, 4);
                packet_bytes.push_back(8'(n));
                push_random(n);
            end
            default:
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 255) : $urandom_range(5, 9);
                packet_bytes.push_back(8'(n));
                push_random(n);
            end
        endcase
    endfunction

    // The declared length does not limit the capture, so it is drawn on its own.
    function automatic void push_match(int ncap);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 255) : $urandom_range(5, 12);
        packet_bytes.push_back(8'(n));
        packet_bytes.push_back(BlockType);
        packet_bytes.push_back(ServiceId[7:0]);
        packet_bytes.push_back(ServiceId[15:8]);
        push_random(ncap);
    endfunction

    task automatic run_random(input int min_bytes);
        int          start;
        int          kind;
        int          ncap;
        int          restart_at;
        int          n;
        logic [47:0] addr;
        bit          headless;
        start = bytes_sent;
        while (bytes_sent - start < min_bytes)
        begin
            packet_bytes.delete();
            kind = $urandom_range(0, 19);
            headless = (kind == 0);
            restart_at = -1;
            if (kind == 1)
            begin
                // Junk, then a new start mark in the middle of the packet.
                push_random($urandom_range(1, 5));
                restart_at = packet_bytes.size();
            end
            if (kind < 15)
            begin
                repeat ($urandom_range(0, 2)) push_filler();
                ncap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 7;
                push_match(ncap);
                if (ncap == 7)
                    push_random($urandom_range(0, 3));
            end
            else if (kind < 17)
            begin
                // The packet ends inside the type or service bytes.
                push_filler();
                packet_bytes.push_back(8'($urandom_range(5, 9)));
                packet_bytes.push_back($urandom_range(0, 1) ? BlockType : 8'($urandom));
                if ($urandom_range(0, 1))
                    packet_bytes.push_back(ServiceId[7:0]);
            end
            else if (kind < 19)
            begin
                // A vendor block whose service id is close to, but not, the one wanted.
                n = $urandom_range(5, 9);
                packet_bytes.push_back(8'(n));
                packet_bytes.push_back(BlockType);
                packet_bytes.push_back(ServiceId[7:0]);
                packet_bytes.push_back(ServiceId[15:8] ^ 8'(1 << $urandom_range(0, 7)));
                push_random(n - 3);
                if ($urandom_range(0, 1))
                    push_match(7);
            end
            else
                push_random($urandom_range(1, 8));
            addr = sb.known_addr;
            case ($urandom_range(0, 9))
                0: addr = {16'($urandom), 32'($urandom)};
                1: addr[$urandom_range(0, 47)] = ~addr[$urandom_range(0, 47)];
                default: ;
            endcase
            send_packet(addr, headless, restart_at);
        end
    endtask

    task automatic settle();
        byte_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic change_address(input logic [47:0] value);
        settle();
        address_we <= 1'b1;
        address_data <= value;
        @(posedge clk);
        address_we <= 1'b0;
        sb.known_addr = value;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // A byte right after reset with no start mark.
        packet_bytes = '{8'h00};
        send_packet(KnownAddressReset, 1'b1, -1);
        // A one-byte packet.
        packet_bytes = '{BlockType};
        send_packet(KnownAddressReset, 1'b0, -1);
        // Empty block, then the shortest matching block with extreme readings.
        packet_bytes = '{8'h00, MinBlock, BlockType, ServiceId[7:0], ServiceId[15:8],
                         8'h00, 8'h80, 8'hff, 8'h7f, 8'hff, 8'hff, 8'h00};
        send_packet(KnownAddressReset, 1'b0, -1);
        packet_bytes = '{MinBlock, BlockType, ServiceId[7:0], ServiceId[15:8], 8'h12};
        send_packet(KnownAddressReset, 1'b0, -1);
        packet_bytes = '{MinBlock, BlockType};
        send_packet(~KnownAddressReset, 1'b0, -1);
        packet_bytes = '{8'h06, BlockType, ServiceId[7:0]};
        send_packet(KnownAddressReset, 1'b0, -1);

        change_address(48'h0);
        run_random(90);
        change_address({48{1'b1}});
        run_random(90);
        change_address({16'($urandom), 32'($urandom)});
        run_random(90);
        idling = 1'b0;
        change_address(KnownAddressReset);
        run_random(90);

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
